// ===== rtl/dpch_pkg.sv =====
`default_nettype none
package dpch_pkg;

  localparam int HistDepth = 64;
  localparam int HistAw    = $clog2(HistDepth);
  localparam int FillW     = $clog2(HistDepth + 1);
  localparam int DebW      = 26;
  localparam int CfgIdxW   = 8;

  localparam logic [9:0]  UsPerMs = 10'd1000;
  localparam logic [19:0] UsPerS  = 20'd1000000;

  localparam logic [DebW-1:0] DebUsReset       = DebW'(500 * 1000);
  localparam logic [19:0]     RateTimeoutReset = 20'd300;

  localparam logic [CfgIdxW-1:0] RegDebounceMs   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegRateTimeout  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegCountBase    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSavedLastWall = CfgIdxW'(3);

  localparam logic OpPulse = 1'b0;
  localparam logic OpQuery = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/dpch_ring.sv =====
`default_nettype none
module dpch_ring (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [dpch_pkg::HistAw-1:0] wr_addr,
  input  wire logic [31:0]                 wr_data,
  input  wire logic                        rd_en,
  input  wire logic [dpch_pkg::HistAw-1:0] rd_addr,
  output logic      [31:0]                 rd_data
);
  import dpch_pkg::*;

  logic [31:0] mem [HistDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/debounced_pulse_counter_history.sv =====
`default_nettype none
// Debounced meter pulse counter with a wall-clock history ring.
// Input channel (in_valid / in_stall): one word per pulse edge or count query.
// Result channel (out_valid / out_stall): exactly one result word per input word,
// in order, held steady while out_stall is high.
// Configuration channel (cfg_valid / cfg_ready, cfg_ready always high): index 0
// debounce in ms, 1 rate timeout in s, 2 restored count base, 3 restored last
// wall second (also loads the live last wall second); other indexes are ignored.
// A pulse edge passes through states StEval and StPfin after acceptance; its
// result word is registered from StPfin once the output register is free.
// A query walks the ring newest first, one entry per cycle through the single
// read port of the ring memory, until an entry is not later than the query
// second or all filled entries of the 64-entry ring are read; an empty ring
// skips the walk and goes straight to its result word.
// One word is worked on at a time; the next is taken once the current result
// sits in the output register, so a waiting result does not block acceptance.
// A stalled receiver holds the result register and the engine waits before it
// commits the following word. Reset clears count, ring head and fill, debounce
// history and restores register defaults (500 ms, 300 s, base 0, last wall 0).
module debounced_pulse_counter_history (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_operation,
  input  wire logic [47:0]                   in_stamp_us,
  input  wire logic [31:0]                   in_wall_s,
  input  wire logic                          in_wall_time_valid,
  input  wire logic [31:0]                   in_query_s,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_accepted,
  output logic      [31:0]                   out_pulse_count,
  output logic      [47:0]                   out_interval_us,
  output logic      [31:0]                   out_count_at_query,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dpch_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import dpch_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEval = 3'd1;
  localparam logic [2:0] StPfin = 3'd2;
  localparam logic [2:0] StWalk = 3'd3;
  localparam logic [2:0] StQfin = 3'd4;

  logic [2:0]        state_r, state_nxt;

  logic [DebW-1:0]   deb_us_r;
  logic [19:0]       rate_timeout_r;
  logic [31:0]       count_base_r;
  logic [31:0]       last_wall_r;
  logic [47:0]       last_accept_r;
  logic              have_r;
  logic [31:0]       counted_r;
  logic [HistAw-1:0] head_r;
  logic [FillW-1:0]  fill_r;

  logic [47:0]       stamp_r;
  logic [31:0]       wall_r;
  logic              wall_ok_r;
  logic [31:0]       query_r;

  logic              drop_r;
  logic [47:0]       diff_r;
  logic              first_ok_r;
  logic [19:0]       gap_r;
  logic [FillW-1:0]  newer_r, newer_nxt;

  logic              out_valid_r;
  logic              out_acc_r;
  logic [31:0]       out_cnt_r;
  logic [47:0]       out_int_r;
  logic [31:0]       out_caq_r;

  logic              out_free;
  logic [DebW-1:0]   deb_prod;
  logic [48:0]       diff;
  logic [31:0]       gap;
  logic [39:0]       gap_prod;
  logic [31:0]       total;
  logic [31:0]       counted_inc;
  logic [47:0]       interval;
  logic              rd_en;
  logic [FillW-1:0]  rd_k;
  logic [HistAw-1:0] rd_addr;
  logic [31:0]       rd_data;
  logic [FillW:0]    addr_wide;
  logic              ring_full;
  logic              walk_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != StIdle);
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_pulse_count    = out_cnt_r;
  assign out_interval_us    = out_int_r;
  assign out_count_at_query = out_caq_r;

  assign deb_prod    = {10'd0, cfg_data[15:0]} * {16'd0, UsPerMs};
  assign diff        = {1'b0, stamp_r} - {1'b0, last_accept_r};
  assign gap         = wall_r - last_wall_r;
  assign gap_prod    = {20'd0, gap_r} * {20'd0, UsPerS};
  assign total       = count_base_r + counted_r;
  assign counted_inc = counted_r + 32'd1;
  assign ring_full   = (fill_r == FillW'(HistDepth));
  assign walk_hit    = (rd_data > query_r);

  always_comb begin
    if (have_r) begin
      interval = diff_r;
    end else if (first_ok_r) begin
      interval = {8'd0, gap_prod};
    end else begin
      interval = 48'd0;
    end
  end

  // ring entry k places back from the newest
  always_comb begin
    if ({1'b0, head_r} > rd_k) begin
      addr_wide = (FillW + 1)'(head_r) - (FillW + 1)'(rd_k) - (FillW + 1)'(1);
    end else begin
      addr_wide = (FillW + 1)'(head_r) + (FillW + 1)'(HistDepth - 1) - (FillW + 1)'(rd_k);
    end
  end
  assign rd_addr = addr_wide[HistAw-1:0];

  always_comb begin
    state_nxt = state_r;
    newer_nxt = newer_r;
    rd_en     = 1'b0;
    rd_k      = '0;
    unique case (state_r)
      StIdle: begin
        if (in_valid) begin
          if (in_operation == OpQuery) begin
            newer_nxt = '0;
            if (fill_r == '0) begin
              state_nxt = StQfin;
            end else begin
              rd_en     = 1'b1;
              state_nxt = StWalk;
            end
          end else begin
            state_nxt = StEval;
          end
        end
      end
      StEval: begin
        state_nxt = StPfin;
      end
      StPfin: begin
        if (out_free) begin
          state_nxt = StIdle;
        end
      end
      StWalk: begin
        if (walk_hit) begin
          newer_nxt = newer_r + FillW'(1);
          if (newer_nxt == fill_r) begin
            state_nxt = StQfin;
          end else begin
            rd_k  = newer_nxt;
            rd_en = 1'b1;
          end
        end else begin
          state_nxt = StQfin;
        end
      end
      StQfin: begin
        if (out_free) begin
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  dpch_ring u_ring (
    .clk     (clk),
    .wr_en   (state_r == StPfin && out_free && !drop_r),
    .wr_addr (head_r),
    .wr_data (wall_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= StIdle;
      deb_us_r       <= DebUsReset;
      rate_timeout_r <= RateTimeoutReset;
      count_base_r   <= '0;
      last_wall_r    <= '0;
      last_accept_r  <= '0;
      have_r         <= 1'b0;
      counted_r      <= '0;
      head_r         <= '0;
      fill_r         <= '0;
      newer_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      newer_r <= newer_nxt;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegDebounceMs:    deb_us_r       <= deb_prod;
          RegRateTimeout:   rate_timeout_r <= cfg_data[19:0];
          RegCountBase:     count_base_r   <= cfg_data;
          RegSavedLastWall: last_wall_r    <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == StPfin && out_free) begin
        out_valid_r <= 1'b1;
        if (!drop_r) begin
          last_accept_r <= stamp_r;
          have_r        <= 1'b1;
          last_wall_r   <= wall_r;
          counted_r     <= counted_inc;
          head_r        <= (head_r == HistAw'(HistDepth - 1)) ? '0 : head_r + HistAw'(1);
          if (!ring_full) begin
            fill_r <= fill_r + FillW'(1);
          end
        end
      end
      if (state_r == StQfin && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == StIdle && in_valid) begin
      stamp_r   <= in_stamp_us;
      wall_r    <= in_wall_s;
      wall_ok_r <= in_wall_time_valid;
      query_r   <= in_query_s;
    end
    if (state_r == StEval) begin
      drop_r     <= have_r && (diff[48] || diff[47:0] < {22'd0, deb_us_r});
      diff_r     <= diff[47:0];
      first_ok_r <= (last_wall_r != '0) && wall_ok_r && (wall_r > last_wall_r) &&
                    (gap <= {12'd0, rate_timeout_r});
      gap_r      <= gap[19:0];
    end
    if (state_r == StPfin && out_free) begin
      out_acc_r <= !drop_r;
      out_cnt_r <= drop_r ? total : count_base_r + counted_inc;
      out_int_r <= drop_r ? 48'd0 : interval;
      out_caq_r <= '0;
    end
    if (state_r == StQfin && out_free) begin
      out_acc_r <= 1'b0;
      out_cnt_r <= total;
      out_int_r <= '0;
      out_caq_r <= (newer_r >= fill_r && ring_full) ? total : total - 32'(newer_r);
    end
  end

endmodule
`default_nettype wire
